// File: rtl/core/rgc_pkg.sv
// shared types and constants for the resource grant controller
// no dependencies; imported by every module of the block
package rgc_pkg;

	localparam int RGC_CUSTOMERS = 8;
	localparam int RGC_KINDS     = 3;
	localparam int RGC_UNIT_W    = 8;
	localparam logic [RGC_UNIT_W-1:0] RGC_CAP_RESET = 8'd5;

	typedef enum logic [1:0] {
		ACT_REQUEST = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_DECLARE = 2'd2,
		ACT_LOAD    = 2'd3
	} action_t;

	typedef logic [RGC_UNIT_W-1:0] unit_t;
	typedef unit_t [RGC_KINDS-1:0] units_t;

	typedef struct packed {
		action_t    action;
		logic [2:0] customer;
		unit_t      amount_a;
		unit_t      amount_b;
		unit_t      amount_c;
	} req_t;

	typedef struct packed {
		logic accepted;
		logic customer_done;
	} rsp_t;

	// one customer row: held and remaining units per kind
	typedef struct packed {
		units_t held;
		units_t remaining;
	} entry_t;

	// outcome of one request, from the ruling logic to the state owners
	typedef struct packed {
		logic   ok;
		logic   entry_we;
		logic   pool_we;
		logic   done_next;
		entry_t entry;
		units_t pool;
	} verdict_t;

endpackage

// File: rtl/core/rgc_store.sv
// per-customer row memory with registered read
// depends on rgc_pkg; valid bits make unwritten rows read as zero
module rgc_store #(
	parameter int CUSTOMERS = rgc_pkg::RGC_CUSTOMERS,
	parameter int AW        = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  rgc_pkg::entry_t wr_data,
	output rgc_pkg::entry_t rd_data
);
	import rgc_pkg::*;

	entry_t               mem [CUSTOMERS];
	logic [CUSTOMERS-1:0] row_valid_q;
	entry_t               rdata_q;
	logic                 rvalid_q;
	logic                 fwd_q;
	entry_t               fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q    <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
			fwd_q       <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= row_valid_q[rd_addr];
				// write to the same row in the read cycle: take the new data
				fwd_q    <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	always_comb begin
		if (fwd_q) begin
			rd_data = fwd_data_q;
		end else if (rvalid_q) begin
			rd_data = rdata_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

// File: rtl/core/rgc_exec.sv
// grant / release / declare / load ruling for one request
// depends on rgc_pkg; purely combinational, three kinds side by side
module rgc_exec (
	input  rgc_pkg::req_t     req,
	input  logic              cust_ok,
	input  logic              done_cur,
	input  rgc_pkg::entry_t   entry,
	input  rgc_pkg::units_t   pool,
	input  rgc_pkg::unit_t    cap,
	output rgc_pkg::verdict_t verdict
);
	import rgc_pkg::*;

	units_t                 amt;
	logic [RGC_KINDS-1:0]   grant_k;
	logic [RGC_KINDS-1:0]   free_k;
	logic [RGC_UNIT_W:0]    held_sum [RGC_KINDS];
	logic [RGC_UNIT_W:0]    pool_sum [RGC_KINDS];
	entry_t                 grant_entry;
	entry_t                 free_entry;
	units_t                 grant_pool;
	units_t                 free_pool;

	assign amt[0] = req.amount_a;
	assign amt[1] = req.amount_b;
	assign amt[2] = req.amount_c;

	always_comb begin
		for (int k = 0; k < RGC_KINDS; k++) begin
			held_sum[k] = {1'b0, entry.held[k]} + {1'b0, amt[k]};
			pool_sum[k] = {1'b0, pool[k]} + {1'b0, amt[k]};
			grant_k[k]  = (amt[k] <= entry.remaining[k]) && (entry.remaining[k] <= pool[k])
				&& (held_sum[k] <= {1'b0, cap});
			free_k[k]   = (amt[k] <= entry.held[k]) && !pool_sum[k][RGC_UNIT_W];
			grant_entry.held[k]      = held_sum[k][RGC_UNIT_W-1:0];
			grant_entry.remaining[k] = entry.remaining[k] - amt[k];
			grant_pool[k]            = pool[k] - amt[k];
			free_entry.held[k]       = entry.held[k] - amt[k];
			free_entry.remaining[k]  = entry.remaining[k];
			free_pool[k]             = pool_sum[k][RGC_UNIT_W-1:0];
		end
	end

	always_comb begin
		verdict           = '0;
		verdict.entry     = entry;
		verdict.pool      = pool;
		verdict.done_next = done_cur;
		unique case (req.action)
			ACT_REQUEST: begin
				verdict.ok       = cust_ok && !done_cur && (&grant_k);
				verdict.entry_we = verdict.ok;
				verdict.pool_we  = verdict.ok;
				verdict.entry    = grant_entry;
				verdict.pool     = grant_pool;
				if (verdict.ok && (grant_entry.remaining == '0)) begin
					verdict.done_next = 1'b1;
				end
			end
			ACT_RELEASE: begin
				verdict.ok       = cust_ok && (&free_k);
				verdict.entry_we = verdict.ok;
				verdict.pool_we  = verdict.ok;
				verdict.entry    = free_entry;
				verdict.pool     = free_pool;
			end
			ACT_DECLARE: begin
				verdict.ok              = cust_ok;
				verdict.entry_we        = cust_ok;
				verdict.entry.remaining = amt;
				if (cust_ok) begin
					verdict.done_next = 1'b0;
				end
			end
			ACT_LOAD: begin
				verdict.ok      = 1'b1;
				verdict.pool_we = 1'b1;
				verdict.pool    = amt;
			end
			default: begin
				verdict.ok = 1'b0;
			end
		endcase
		verdict.done_next = verdict.done_next && cust_ok;
	end

endmodule

// File: rtl/core/resource_grant_controller_core.sv
// path: a request goes through the stage 1 register, then the response register
// throughput: one request per cycle while responses are taken, set by the row memory read/modify/write loop
// back-to-back requests to the same customer are covered by write-to-read forwarding
// reset: pool and finished flags clear, cap = 5, all rows read as zero via valid bits
// top level of the resource grant controller; depends on rgc_pkg, rgc_store, rgc_exec
module resource_grant_controller_core #(
	parameter int CUSTOMERS = rgc_pkg::RGC_CUSTOMERS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  rgc_pkg::unit_t       cfg_wr_data,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  rgc_pkg::req_t        req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rgc_pkg::rsp_t        rsp_data
);
	import rgc_pkg::*;

	localparam int AW = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;

	// request handshake and stage 1 (row read data available)
	logic               accept;
	logic               fire_s1;
	logic               valid_s1;
	req_t               req_s1;
	logic               cust_ok_s1;
	logic [AW+2:0]      rd_ext;
	logic [AW+2:0]      wr_ext;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      addr_s1;

	// architectural state kept in flops
	units_t             pool_q;
	logic [CUSTOMERS-1:0] done_q;
	unit_t              cap_q;

	// row memory and ruling
	entry_t             row_s1;
	logic               done_cur;
	verdict_t           verdict;

	// response register
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	assign fire_s1   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || fire_s1;
	assign accept    = req_valid && req_ready;

	// customer index widened or trimmed to the row address
	assign rd_ext  = {{AW{1'b0}}, req_data.customer};
	assign wr_ext  = {{AW{1'b0}}, req_s1.customer};
	assign rd_addr = rd_ext[AW-1:0];
	assign addr_s1 = wr_ext[AW-1:0];

	assign cust_ok_s1 = (32'(req_s1.customer) < CUSTOMERS);
	assign done_cur   = cust_ok_s1 && done_q[addr_s1];

	// stage 1 register, loaded at the edge the row read is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_data;
		end
	end

	rgc_store #(
		.CUSTOMERS (CUSTOMERS),
		.AW        (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.wr_en   (fire_s1 && verdict.entry_we),
		.wr_addr (addr_s1),
		.wr_data (verdict.entry),
		.rd_data (row_s1)
	);

	rgc_exec u_exec (
		.req      (req_s1),
		.cust_ok  (cust_ok_s1),
		.done_cur (done_cur),
		.entry    (row_s1),
		.pool     (pool_q),
		.cap      (cap_q),
		.verdict  (verdict)
	);

	// cap register, pool and finished flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= RGC_CAP_RESET;
			pool_q <= '0;
			done_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (fire_s1 && verdict.pool_we) begin
				pool_q <= verdict.pool;
			end
			// out-of-range customers never change a flag
			if (fire_s1 && cust_ok_s1) begin
				done_q[addr_s1] <= verdict.done_next;
			end
		end
	end

	// response register, freed by rsp_ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp_q.accepted      <= verdict.ok;
			rsp_q.customer_done <= verdict.done_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
